>>> design/dual_wheel_profile_velocity_pd_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual wheel profile velocity PD core
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PROFILE_VELOCITY_PD_CORE_ASSERT_SVH
`define DUAL_WHEEL_PROFILE_VELOCITY_PD_CORE_ASSERT_SVH

// Same-cycle implication
`define DWP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DWP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dwp_pkg.sv
// ----------------------------------------------------------------------------
// dwp_pkg
// Types, constants and helpers of the dual wheel profile velocity PD core.
// ----------------------------------------------------------------------------
package dwp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_POST,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // one micro-op per step of the tick sequence
  typedef enum logic [3:0] {
    OP_STEP,
    OP_DIST0,
    OP_SPD0,
    OP_DIST1,
    OP_SPD1,
    OP_BRAKE,
    OP_RAMP,
    OP_ERR0,
    OP_KP0,
    OP_KD0,
    OP_ERR1,
    OP_KP1,
    OP_KD1
  } op_t;

  // serial multiplier: signed A operand times unsigned B operand
  localparam int A_W     = 36;
  localparam int B_W     = 32;
  localparam int P_W     = A_W + B_W + 1;
  localparam int CNT_W   = $clog2(B_W);
  localparam int STEP_W  = 23;
  localparam int DELTA_W = 12;

  localparam logic signed [A_W-1:0] TICK_TIME_Q30      = 36'sd536870;
  localparam logic [B_W-1:0]        DIST_PER_PULSE_Q30 = 32'd17700171;
  localparam logic [B_W-1:0]        SPEED_PER_PULSE_Q26 = 32'd2212521486;
  localparam logic [B_W-1:0]        KP_Q28             = 32'd214748364;
  localparam logic [B_W-1:0]        KD_Q28             = 32'd228170137;
  localparam logic signed [31:0]    DRIVE_LIMIT_Q17    = 32'sd1153433600;
  localparam logic [10:0]           FOLD_LIMIT         = 11'd1024;
  localparam logic [12:0]           FOLD_BASE          = 13'd2049;
  localparam logic signed [31:0]    INT32_MAX          = 32'sh7fffffff;
  localparam logic signed [31:0]    INT32_MIN          = 32'sh80000000;

  // fold an encoder count into a signed pulse delta
  function automatic logic signed [DELTA_W-1:0] fold_count(input logic [10:0] count);
    logic [12:0] up;
    up = FOLD_BASE - {2'b00, count};
    if (count > FOLD_LIMIT) begin
      return $signed(up[DELTA_W-1:0]);
    end
    return -$signed({1'b0, count});
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [P_W-1:0] v);
    logic all_ones;
    logic all_zeros;
    all_ones  = &v[P_W-1:31];
    all_zeros = ~|v[P_W-1:31];
    if (all_ones || all_zeros) begin
      return v[31:0];
    end
    return v[P_W-1] ? INT32_MIN : INT32_MAX;
  endfunction

endpackage

>>> design/dwp_in_if.sv
// ----------------------------------------------------------------------------
// dwp_in_if
// Command and encoder sample channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dwp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [10:0]        right_count;
  logic [10:0]        left_count;
  logic [18:0]        right_gain;
  logic [18:0]        left_gain;
  logic signed [31:0] target_distance;
  logic [30:0]        decel_distance;
  logic signed [31:0] target_speed;
  logic signed [31:0] decel_speed;
  logic [15:0]        accel;

  modport source (
    output valid, command, right_count, left_count, right_gain, left_gain,
           target_distance, decel_distance, target_speed, decel_speed, accel,
    input  ready
  );
  modport sink (
    input  valid, command, right_count, left_count, right_gain, left_gain,
           target_distance, decel_distance, target_speed, decel_speed, accel,
    output ready
  );
endinterface

>>> design/dwp_out_if.sv
// ----------------------------------------------------------------------------
// dwp_out_if
// Status result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dwp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] right_speed_avg;
  logic signed [31:0] left_speed_avg;
  logic signed [31:0] right_profile_speed;
  logic signed [31:0] left_profile_speed;
  logic signed [31:0] right_drive;
  logic signed [31:0] left_drive;
  logic signed [31:0] mean_travel;
  logic               decel_armed;

  modport source (
    output valid, right_speed_avg, left_speed_avg, right_profile_speed,
           left_profile_speed, right_drive, left_drive, mean_travel, decel_armed,
    input  ready
  );
  modport sink (
    input  valid, right_speed_avg, left_speed_avg, right_profile_speed,
           left_profile_speed, right_drive, left_drive, mean_travel, decel_armed,
    output ready
  );
endinterface

>>> design/dual_wheel_profile_velocity_pd_core.sv
// ----------------------------------------------------------------------------
// dual_wheel_profile_velocity_pd_core
// Two-wheel trapezoidal speed profile with an incremental PD speed loop.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command transaction: a tick with both encoder counts and
//   steering gains, a move set, or a move end. out_ch returns exactly one
//   status transaction for each command: average speeds, profile speeds, drive
//   accumulators, mean travel and the decel-armed flag.
//   A tick runs as a sequence of eleven products on one radix-2 shift-add
//   multiplier (each a load step, the shift-add iterations and a write-back
//   step) and two plain steps (load and write-back); the status is then
//   loaded into the output register. Move commands and the unused command
//   code skip the multiplier and go straight to the output state. One command
//   is in flight at a time: in_ch.ready is high only in idle. The result sits
//   in an output register, so the next command is accepted while a result
//   still waits; when the receiver stalls with a result held
//   and another one finished, the sequencer holds until the register frees.
//   Synchronous active-low reset clears all motion state to zero and empties
//   the output register.
// ----------------------------------------------------------------------------
`include "dual_wheel_profile_velocity_pd_core_assert.svh"

module dual_wheel_profile_velocity_pd_core (
  input  logic clk,
  input  logic rst_n,
  dwp_in_if.sink    in_ch,
  dwp_out_if.source out_ch
);
  import dwp_pkg::*;

  // Sequencer
  state_t state_r, state_nxt;
  op_t    op_r;
  logic   wsel;
  logic   op_mult;
  logic   in_fire;
  logic   out_free;

  // Tick operands captured at accept
  logic signed [DELTA_W-1:0] delta_r [2];
  logic [18:0]               gain_r  [2];

  // Motion state
  logic [31:0]        dist_r   [2];
  logic signed [31:0] prev_r   [2];
  logic signed [31:0] avg_r    [2];
  logic signed [31:0] prof_r   [2];
  logic signed [31:0] hist_r   [8];
  logic signed [31:0] drive_r  [2];
  logic signed [31:0] goal_dist_r;
  logic signed [31:0] goal_speed_r;
  logic signed [31:0] brake_dist_r;
  logic signed [31:0] brake_speed_r;
  logic [15:0]        ramp_r;
  logic               pending_r;
  logic [STEP_W-1:0]  step_r;
  logic signed [31:0] prop_r;

  // Serial multiplier
  logic signed [A_W-1:0] mul_a_r;
  logic signed [A_W:0]   mul_hi_r;
  logic [B_W-1:0]        mul_lo_r;
  logic [CNT_W-1:0]      mul_cnt_r;
  logic signed [A_W+1:0] mul_sum;
  logic signed [A_W-1:0] ld_a;
  logic [B_W-1:0]        ld_b;

  // Output register
  logic               out_valid_r;
  logic signed [31:0] o_ravg_r, o_lavg_r, o_rprof_r, o_lprof_r;
  logic signed [31:0] o_rdrv_r, o_ldrv_r, o_mean_r;
  logic               o_armed_r;

  // Write-back datapath
  logic signed [P_W-1:0] prod, sh9, sh13, sh17, sh28;
  logic signed [31:0]    spd;
  logic signed [32:0]    avg_sum;
  logic [2:0]            hbase;
  logic signed [A_W-1:0] der_d1, der_d2, der;
  logic signed [32:0]    rem;
  logic signed [33:0]    abs_rem;
  logic signed [31:0]    ramp_nxt [2];
  logic signed [P_W-1:0] err_v;
  logic signed [35:0]    acc;
  logic signed [31:0]    acc_sat;
  logic signed [32:0]    mean_sum;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Wheel of the current micro-op
  always_comb begin
    unique case (op_r)
      OP_DIST1, OP_SPD1, OP_ERR1, OP_KP1, OP_KD1: wsel = 1'b1;
      default:                                    wsel = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op_r)
      OP_BRAKE, OP_RAMP: op_mult = 1'b0;
      default:           op_mult = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (cmd_t'(in_ch.command) == CMD_TICK) ? ST_LOAD : ST_OUT;
        end
      end
      ST_LOAD: state_nxt = op_mult ? ST_MUL : ST_POST;
      ST_MUL: begin
        if (mul_cnt_r == CNT_W'(B_W - 1)) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: state_nxt = (op_r == OP_KD1) ? ST_OUT : ST_LOAD;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = out_valid_r;
  end

  assign out_ch.right_speed_avg     = o_ravg_r;
  assign out_ch.left_speed_avg      = o_lavg_r;
  assign out_ch.right_profile_speed = o_rprof_r;
  assign out_ch.left_profile_speed  = o_lprof_r;
  assign out_ch.right_drive         = o_rdrv_r;
  assign out_ch.left_drive          = o_ldrv_r;
  assign out_ch.mean_travel         = o_mean_r;
  assign out_ch.decel_armed         = o_armed_r;

  // PD derivative term from the error history of the current wheel
  assign hbase  = {wsel, 2'b00};
  assign der_d1 = A_W'(hist_r[hbase]) - A_W'(hist_r[hbase + 3'd3]);
  assign der_d2 = A_W'(hist_r[hbase + 3'd1]) - A_W'(hist_r[hbase + 3'd2]);
  assign der    = der_d1 + der_d2 + (der_d2 <<< 1);

  // Operand select for the next product
  always_comb begin
    ld_a = '0;
    ld_b = '0;
    unique case (op_r)
      OP_STEP: begin
        ld_a = TICK_TIME_Q30;
        ld_b = B_W'(ramp_r);
      end
      OP_DIST0, OP_DIST1: begin
        ld_a = A_W'(delta_r[wsel]);
        ld_b = DIST_PER_PULSE_Q30;
      end
      OP_SPD0, OP_SPD1: begin
        ld_a = A_W'(delta_r[wsel]);
        ld_b = SPEED_PER_PULSE_Q26;
      end
      OP_ERR0, OP_ERR1: begin
        ld_a = A_W'(prof_r[wsel]);
        ld_b = B_W'(gain_r[wsel]);
      end
      OP_KP0, OP_KP1: begin
        ld_a = A_W'(hist_r[hbase]);
        ld_b = KP_Q28;
      end
      OP_KD0, OP_KD1: begin
        ld_a = der;
        ld_b = KD_Q28;
      end
      default: begin
        ld_a = '0;
        ld_b = '0;
      end
    endcase
  end

  // One multiplier bit per cycle: add A when the low bit is set, then shift
  assign mul_sum = (A_W + 2)'(mul_hi_r) + (mul_lo_r[0] ? (A_W + 2)'(mul_a_r) : '0);

  assign prod = $signed({mul_hi_r, mul_lo_r});
  assign sh9  = prod >>> 9;
  assign sh13 = prod >>> 13;
  assign sh17 = prod >>> 17;
  assign sh28 = prod >>> 28;

  // Per-tick speed and two-sample average
  assign spd     = sat32(sh9);
  assign avg_sum = 33'(spd) + 33'(prev_r[wsel]);

  // Remaining distance seen from the right wheel
  assign rem     = 33'(goal_dist_r) - 33'($signed(dist_r[0]));
  assign abs_rem = rem[32] ? -34'(rem) : 34'(rem);

  // Ramp each profile toward the goal without overshoot
  always_comb begin
    logic signed [32:0] p;
    logic signed [32:0] g;
    logic signed [32:0] up;
    logic signed [32:0] dn;
    for (int w = 0; w < 2; w++) begin
      p  = 33'(prof_r[w]);
      g  = 33'(goal_speed_r);
      up = p + $signed({10'd0, step_r});
      dn = p - $signed({10'd0, step_r});
      if (g > p) begin
        ramp_nxt[w] = (up > g) ? goal_speed_r : up[31:0];
      end else if (g < p) begin
        ramp_nxt[w] = (dn < g) ? goal_speed_r : dn[31:0];
      end else begin
        ramp_nxt[w] = prof_r[w];
      end
    end
  end

  // Speed error and accumulator update
  assign err_v = sh17 - P_W'(avg_r[wsel]);
  assign acc   = 36'(drive_r[wsel]) + 36'(prop_r) + sh28[35:0];

  always_comb begin
    if (acc > 36'(DRIVE_LIMIT_Q17)) begin
      acc_sat = DRIVE_LIMIT_Q17;
    end else if (acc < -36'(DRIVE_LIMIT_Q17)) begin
      acc_sat = -DRIVE_LIMIT_Q17;
    end else begin
      acc_sat = acc[31:0];
    end
  end

  assign mean_sum = 33'($signed(dist_r[0])) + 33'($signed(dist_r[1]));

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_STEP;
      mul_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_fire) begin
        op_r <= OP_STEP;
      end else if (state_r == ST_POST && op_r != OP_KD1) begin
        op_r <= op_t'(op_r + 4'd1);
      end
      if (state_r == ST_MUL) begin
        mul_cnt_r <= mul_cnt_r + CNT_W'(1);
      end else begin
        mul_cnt_r <= '0;
      end
      // set wins over the drain of the previous result
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < 2; w++) begin
        dist_r[w]  <= '0;
        prev_r[w]  <= '0;
        avg_r[w]   <= '0;
        prof_r[w]  <= '0;
        drive_r[w] <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        hist_r[i] <= '0;
      end
      goal_dist_r   <= '0;
      goal_speed_r  <= '0;
      brake_dist_r  <= '0;
      brake_speed_r <= '0;
      ramp_r        <= '0;
      pending_r     <= 1'b0;
    end else begin
      if (state_r == ST_IDLE && in_fire) begin
        unique case (cmd_t'(in_ch.command))
          CMD_MOVE, CMD_END: begin
            ramp_r       <= in_ch.accel;
            goal_dist_r  <= in_ch.target_distance;
            goal_speed_r <= in_ch.target_speed;
            pending_r    <= 1'b1;
            if (cmd_t'(in_ch.command) == CMD_MOVE) begin
              brake_dist_r  <= $signed({1'b0, in_ch.decel_distance});
              brake_speed_r <= in_ch.decel_speed;
            end else begin
              // move end brakes to a stop at the goal itself
              brake_dist_r  <= in_ch.target_distance;
              brake_speed_r <= '0;
            end
          end
          default: begin
          end
        endcase
      end else if (state_r == ST_POST) begin
        unique case (op_r)
          OP_DIST0, OP_DIST1: begin
            dist_r[wsel] <= dist_r[wsel] + sh13[31:0];
          end
          OP_SPD0, OP_SPD1: begin
            avg_r[wsel]  <= avg_sum[32:1];
            prev_r[wsel] <= spd;
          end
          OP_BRAKE: begin
            if (pending_r && (34'(brake_dist_r) >= abs_rem)) begin
              goal_speed_r <= brake_speed_r;
              pending_r    <= 1'b0;
            end
          end
          OP_RAMP: begin
            prof_r[0] <= ramp_nxt[0];
            prof_r[1] <= ramp_nxt[1];
          end
          OP_ERR0, OP_ERR1: begin
            // advance the error history, newest first
            hist_r[hbase + 3'd3] <= hist_r[hbase + 3'd2];
            hist_r[hbase + 3'd2] <= hist_r[hbase + 3'd1];
            hist_r[hbase + 3'd1] <= hist_r[hbase];
            hist_r[hbase]        <= sat32(err_v);
          end
          OP_KD0, OP_KD1: begin
            drive_r[wsel] <= acc_sat;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      delta_r[0] <= fold_count(in_ch.right_count);
      delta_r[1] <= fold_count(in_ch.left_count);
      gain_r[0]  <= in_ch.right_gain;
      gain_r[1]  <= in_ch.left_gain;
    end
    if (state_r == ST_LOAD) begin
      mul_a_r  <= ld_a;
      mul_hi_r <= '0;
      mul_lo_r <= ld_b;
    end else if (state_r == ST_MUL) begin
      mul_hi_r <= mul_sum[A_W+1:1];
      mul_lo_r <= {mul_sum[0], mul_lo_r[B_W-1:1]};
    end
    if (state_r == ST_POST && op_r == OP_STEP) begin
      step_r <= sh13[STEP_W-1:0];
    end
    if (state_r == ST_POST && (op_r == OP_KP0 || op_r == OP_KP1)) begin
      prop_r <= sh28[31:0];
    end
    if (state_r == ST_OUT && out_free) begin
      o_ravg_r  <= avg_r[0];
      o_lavg_r  <= avg_r[1];
      o_rprof_r <= prof_r[0];
      o_lprof_r <= prof_r[1];
      o_rdrv_r  <= drive_r[0];
      o_ldrv_r  <= drive_r[1];
      o_mean_r  <= mean_sum[32:1];
      o_armed_r <= pending_r;
    end
  end

  // Assertions
  `DWP_ASSERT_NXT(a_tick_starts, in_fire && (in_ch.command == CMD_TICK), (state_r == ST_LOAD) && (op_r == OP_STEP), "tick did not start the sequence")
  `DWP_ASSERT_NXT(a_move_arms, in_fire && ((in_ch.command == CMD_MOVE) || (in_ch.command == CMD_END)), pending_r, "move did not arm decel")
  `DWP_ASSERT_IMP(a_disarm_at_brake, $fell(pending_r), $past(state_r == ST_POST) && $past(op_r == OP_BRAKE), "decel disarmed outside the brake step")
  `DWP_ASSERT_IMP(a_drive_bound, 1'b1, (drive_r[0] <= DRIVE_LIMIT_Q17) && (drive_r[0] >= -DRIVE_LIMIT_Q17) && (drive_r[1] <= DRIVE_LIMIT_Q17) && (drive_r[1] >= -DRIVE_LIMIT_Q17), "drive accumulator out of range")

endmodule
